// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. Each macro expects clk and rst_n in
// the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lac_pkg.sv =====
// ----------------------------------------------------------------------------
// lac_pkg
// Shared widths, codes and controller/datapath interface types for the
// label adjacency counter.
// ----------------------------------------------------------------------------
package lac_pkg;

    localparam int ACTION_W     = 2;
    localparam int LABEL_W      = 7;
    localparam int EDGE_W       = 22;
    localparam int WIDTH_CFG_W  = 11;
    localparam int REGION_CFG_W = 7;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_IDX_W    = 2;

    localparam logic [WIDTH_CFG_W-1:0]  IMAGE_WIDTH_RESET  = 11'd1024;
    localparam logic [REGION_CFG_W-1:0] REGION_COUNT_RESET = 7'd64;

    // Transaction actions
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PIXEL = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 2'd1;

    typedef enum logic [1:0] {
        ADDR_LEFT,
        ADDR_UP,
        ADDR_QUERY,
        ADDR_SWEEP
    } addr_sel_t;

    typedef struct packed {
        logic      pixel_step;   // latch pixel, access line store, advance column
        logic      query_load;   // latch read pair labels
        logic      frame_start;  // reset column, left label, first-row flag
        logic      sweep;        // zero one entry per cycle
        logic      sweep_full;   // sweep also clears the line store
        logic      mem_rd;       // read pair counter
        logic      mem_wr;       // write incremented pair counter
        addr_sel_t addr_sel;
        logic      out_load;     // load output register
    } cmd_t;

    typedef struct packed {
        logic left_hit;
        logic up_hit;
        logic sweep_last;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/lac_ctrl.sv =====
// ----------------------------------------------------------------------------
// lac_ctrl
// Sequencer: clearing sweeps, pixel read-modify-write steps and pair reads.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lac_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lac_pkg::ACTION_W-1:0]   action,
    input  lac_pkg::status_t               status,
    output lac_pkg::cmd_t                  cmd
);
    import lac_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_PIX   = 3'd2;
    localparam logic [2:0] ST_L_WR  = 3'd3;
    localparam logic [2:0] ST_U_RD  = 3'd4;
    localparam logic [2:0] ST_U_WR  = 3'd5;
    localparam logic [2:0] ST_Q_RD  = 3'd6;
    localparam logic [2:0] ST_Q_OUT = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       full_reg, full_next;
    logic       accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        full_next      = full_reg;
        cmd            = '0;
        cmd.addr_sel   = ADDR_SWEEP;
        cmd.sweep_full = full_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_CLEAR:
                        begin
                            cmd.frame_start = 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        ACT_PIXEL:
                        begin
                            cmd.pixel_step = 1'b1;
                            state_next     = ST_PIX;
                        end
                        ACT_READ:
                        begin
                            cmd.query_load = 1'b1;
                            state_next     = ST_Q_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    full_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_PIX:
            begin
                if (status.left_hit)
                begin
                    cmd.mem_rd   = 1'b1;
                    cmd.addr_sel = ADDR_LEFT;
                    state_next   = ST_L_WR;
                end
                else if (status.up_hit)
                begin
                    cmd.mem_rd   = 1'b1;
                    cmd.addr_sel = ADDR_UP;
                    state_next   = ST_U_WR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_L_WR:
            begin
                cmd.mem_wr   = 1'b1;
                cmd.addr_sel = ADDR_LEFT;
                state_next   = status.up_hit ? ST_U_RD : ST_IDLE;
            end
            ST_U_RD:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_UP;
                state_next   = ST_U_WR;
            end
            ST_U_WR:
            begin
                cmd.mem_wr   = 1'b1;
                cmd.addr_sel = ADDR_UP;
                state_next   = ST_IDLE;
            end
            ST_Q_RD:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_QUERY;
                state_next   = ST_Q_OUT;
            end
            ST_Q_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            full_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            full_reg  <= full_next;
        end
    end

    `ASSERT_IMPLIES(a_out_load_free, cmd.out_load, status.out_free,
                    "result loaded over a waiting result")
    `ASSERT_IMPLIES(a_full_sweep_only_clear, full_reg, state_reg == ST_CLEAR,
                    "reset sweep left unfinished")
    `ASSERT_NEXT(a_read_to_query, accept && (action == ACT_READ), state_reg == ST_Q_RD,
                 "read transaction did not start a pair read")

endmodule

// ===== hw/rtl/lac_datapath.sv =====
// ----------------------------------------------------------------------------
// lac_datapath
// Pair-count memory, line store, frame position, config and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lac_datapath #(
    parameter int MAX_LABELS = 64,
    parameter int MAX_WIDTH  = 1024,
    parameter int COUNT_BITS = 22
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [lac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lac_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [lac_pkg::LABEL_W-1:0]       label,
    input  logic [lac_pkg::LABEL_W-1:0]       row_label,
    input  logic [lac_pkg::LABEL_W-1:0]       col_label,
    input  lac_pkg::cmd_t                     cmd,
    output lac_pkg::status_t                  status,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [lac_pkg::EDGE_W-1:0]        edge_count
);
    import lac_pkg::*;

    localparam int PAIR_DEPTH = MAX_LABELS * MAX_LABELS;
    localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int SWEEP_LEN  = (PAIR_DEPTH > MAX_WIDTH) ? PAIR_DEPTH : MAX_WIDTH;
    localparam int SWEEP_W    = $clog2(SWEEP_LEN);
    localparam int RL_W       = (WIDTH_CFG_W > $clog2(MAX_WIDTH + 1)) ?
                                WIDTH_CFG_W : $clog2(MAX_WIDTH + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // configuration
    logic [WIDTH_CFG_W-1:0]  image_width_reg;
    logic [REGION_CFG_W-1:0] region_count_reg;

    // frame position
    logic [COL_W-1:0]   column_pos_reg;
    logic [LABEL_W-1:0] left_label_reg;
    logic               first_row_reg;

    // per-transaction payload
    logic [LABEL_W-1:0]    lab_reg;
    logic [LABEL_W-1:0]    left_prev_reg;
    logic                  pos_nz_reg;
    logic                  first_prev_reg;
    logic [LABEL_W-1:0]    line_rd_reg;
    logic [LABEL_W-1:0]    ra_reg;
    logic [LABEL_W-1:0]    cb_reg;
    logic [COUNT_BITS-1:0] pair_rd_reg;
    logic [EDGE_W-1:0]     edge_count_reg;
    logic                  out_valid_reg;

    logic [SWEEP_W-1:0]    sweep_cnt_reg;

    logic [LABEL_W-1:0]    line_mem [MAX_WIDTH];
    logic [COUNT_BITS-1:0] pair_mem [PAIR_DEPTH];

    logic [RL_W-1:0]       width_ext;
    logic [RL_W-1:0]       row_len;
    logic [RL_W-1:0]       pos_inc;
    logic                  row_wrap;
    logic [COL_W-1:0]      col_next;

    logic                  sweep_in_pairs;
    logic                  sweep_in_line;
    logic                  sweep_last;

    logic                  line_we;
    logic [COL_W-1:0]      line_waddr;
    logic [LABEL_W-1:0]    line_wdata;

    logic                  pair_we;
    logic [PAIR_AW-1:0]    pair_addr;
    logic [COUNT_BITS-1:0] pair_wdata;

    logic                  q_ok;
    logic                  q_eq;
    logic [COUNT_BITS+EDGE_W-1:0] count_wide;
    logic [EDGE_W-1:0]     edge_value;

    function automatic logic label_ok(input logic [LABEL_W-1:0] lab,
                                      input logic [REGION_CFG_W-1:0] rc);
        return (lab != '0) && (lab <= rc) && (32'(lab) <= 32'(MAX_LABELS));
    endfunction

    function automatic logic [PAIR_AW-1:0] pair_index(input logic [LABEL_W-1:0] a,
                                                      input logic [LABEL_W-1:0] b);
        logic [LABEL_W-1:0] lo;
        logic [LABEL_W-1:0] hi;
        logic [31:0]        flat;
        lo   = (a < b) ? a : b;
        hi   = (a < b) ? b : a;
        flat = (32'(lo) - 32'd1) * 32'(MAX_LABELS) + 32'(hi) - 32'd1;
        return flat[PAIR_AW-1:0];
    endfunction

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RESET;
            region_count_reg <= REGION_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WIDTH_CFG_W-1:0];
                CFG_REGION_COUNT: region_count_reg <= cfg_data[REGION_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // row length: zero acts as one, clamp to line store depth
    assign width_ext = RL_W'(image_width_reg);
    assign row_len   = (width_ext == '0) ? RL_W'(1) :
                       (width_ext > RL_W'(MAX_WIDTH)) ? RL_W'(MAX_WIDTH) : width_ext;
    assign pos_inc   = RL_W'(column_pos_reg) + RL_W'(1);
    assign row_wrap  = (pos_inc >= row_len);
    assign col_next  = row_wrap ? '0 : pos_inc[COL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_pos_reg <= '0;
            left_label_reg <= '0;
            first_row_reg  <= 1'b1;
        end
        else if (cmd.frame_start)
        begin
            column_pos_reg <= '0;
            left_label_reg <= '0;
            first_row_reg  <= 1'b1;
        end
        else if (cmd.pixel_step)
        begin
            column_pos_reg <= col_next;
            left_label_reg <= label;
            if (row_wrap)
            begin
                first_row_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pixel_step)
        begin
            lab_reg        <= label;
            left_prev_reg  <= left_label_reg;
            pos_nz_reg     <= (column_pos_reg != '0);
            first_prev_reg <= first_row_reg;
        end
        if (cmd.query_load)
        begin
            ra_reg <= row_label;
            cb_reg <= col_label;
        end
        if (cmd.out_load)
        begin
            edge_count_reg <= edge_value;
        end
    end

    // clearing sweep
    assign sweep_in_pairs = ({1'b0, sweep_cnt_reg} < (SWEEP_W+1)'(PAIR_DEPTH));
    assign sweep_in_line  = ({1'b0, sweep_cnt_reg} < (SWEEP_W+1)'(MAX_WIDTH));
    assign sweep_last     = cmd.sweep_full ? (sweep_cnt_reg == SWEEP_W'(SWEEP_LEN - 1)) :
                                             (sweep_cnt_reg == SWEEP_W'(PAIR_DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
        end
        else if (cmd.sweep)
        begin
            sweep_cnt_reg <= sweep_last ? '0 : sweep_cnt_reg + SWEEP_W'(1);
        end
    end

    // line store: old label read, new label written at the same column
    assign line_we    = cmd.pixel_step || (cmd.sweep && cmd.sweep_full && sweep_in_line);
    assign line_waddr = cmd.pixel_step ? column_pos_reg : sweep_cnt_reg[COL_W-1:0];
    assign line_wdata = cmd.pixel_step ? label : '0;

    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_waddr] <= line_wdata;
        end
        if (cmd.pixel_step)
        begin
            line_rd_reg <= line_mem[column_pos_reg];
        end
    end

    // pair counters
    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_LEFT:  pair_addr = pair_index(left_prev_reg, lab_reg);
            ADDR_UP:    pair_addr = pair_index(line_rd_reg, lab_reg);
            ADDR_QUERY: pair_addr = pair_index(ra_reg, cb_reg);
            default:    pair_addr = sweep_cnt_reg[PAIR_AW-1:0];
        endcase
    end

    assign pair_we    = cmd.mem_wr || (cmd.sweep && sweep_in_pairs);
    assign pair_wdata = cmd.sweep ? '0 :
                        (pair_rd_reg == COUNT_MAX) ? pair_rd_reg :
                        pair_rd_reg + COUNT_BITS'(1);

    always_ff @(posedge clk)
    begin
        if (pair_we)
        begin
            pair_mem[pair_addr] <= pair_wdata;
        end
        if (cmd.mem_rd)
        begin
            pair_rd_reg <= pair_mem[pair_addr];
        end
    end

    // read result
    assign q_ok       = label_ok(ra_reg, region_count_reg) && label_ok(cb_reg, region_count_reg);
    assign q_eq       = (ra_reg == cb_reg);
    assign count_wide = {{EDGE_W{1'b0}}, pair_rd_reg};
    assign edge_value = !q_ok ? '0 : q_eq ? EDGE_W'(1) : count_wide[EDGE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign edge_count = edge_count_reg;

    assign status.left_hit   = pos_nz_reg && label_ok(left_prev_reg, region_count_reg) &&
                               label_ok(lab_reg, region_count_reg) && (left_prev_reg != lab_reg);
    assign status.up_hit     = !first_prev_reg && label_ok(line_rd_reg, region_count_reg) &&
                               label_ok(lab_reg, region_count_reg) && (line_rd_reg != lab_reg);
    assign status.sweep_last = sweep_last;
    assign status.out_free   = !out_valid_reg || !out_stall;

    `ASSERT_IMPLIES(a_sweep_cnt_parked, !cmd.sweep, sweep_cnt_reg == '0,
                    "sweep counter not parked")
    `ASSERT_IMPLIES(a_inc_nonzero, cmd.mem_wr, pair_wdata != '0,
                    "counter update wrote zero")
    `ASSERT_NEXT(a_out_hold, out_valid_reg && out_stall,
                 out_valid_reg && $stable(edge_count_reg),
                 "stalled result changed or dropped")

endmodule

// ===== hw/rtl/label_adjacency_counter_top.sv =====
// ----------------------------------------------------------------------------
// label_adjacency_counter_top
// Region adjacency counter: counts 4-connected crack edges between label
// pairs of a raster-order label image and answers pair-count reads.
// ----------------------------------------------------------------------------
//
//   channel | signals                                      | direction
//   --------+----------------------------------------------+----------
//   in      | in_valid/in_stall, action, label, row/col    | to block
//   out     | out_valid/out_stall, edge_count              | from block
//   cfg     | cfg_wr_en, cfg_index, cfg_data               | to block
//
// Pixel transaction: a pair-memory read then write for each counting neighbor
// pair (single-port pair memory, left first); none with no counting pair.
// Read transaction: a pair read plus any wait for the output register; a result
// waits there while the next transaction is accepted.
// Reset sweeps both memories over max(MAX_LABELS^2, MAX_WIDTH) entries, a clear
// sweeps the MAX_LABELS^2 pair memory entries; in_stall is high while busy.
//
module label_adjacency_counter_top #(
    parameter int MAX_LABELS = 64,
    parameter int MAX_WIDTH  = 1024,
    parameter int COUNT_BITS = 22
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [lac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lac_pkg::CFG_DATA_W-1:0]    cfg_data,

    // input transactions
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lac_pkg::ACTION_W-1:0]      action,
    input  logic [lac_pkg::LABEL_W-1:0]       label,
    input  logic [lac_pkg::LABEL_W-1:0]       row_label,
    input  logic [lac_pkg::LABEL_W-1:0]       col_label,

    // result transactions
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lac_pkg::EDGE_W-1:0]        edge_count
);
    import lac_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: owns the handshake on the input side
    lac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .status   (status),
        .cmd      (cmd)
    );

    // memories, frame position, config and output register
    lac_datapath #(
        .MAX_LABELS (MAX_LABELS),
        .MAX_WIDTH  (MAX_WIDTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .label      (label),
        .row_label  (row_label),
        .col_label  (col_label),
        .cmd        (cmd),
        .status     (status),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .edge_count (edge_count)
    );

endmodule

// ===== dv/label_adjacency_counter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_adjacency_counter_top_tb
// Self-checking bench for the label adjacency counter. Streams label images
// and pair reads through the valid/stall input channel under random idling,
// tracks crack-edge counts in a bench-side copy of the pair table and line
// buffer, and checks every edge_count result in order.
// ----------------------------------------------------------------------------
module label_adjacency_counter_top_tb;

    import lac_pkg::*;

    localparam int MAX_LABELS = 64;
    localparam int MAX_WIDTH  = 1024;
    localparam int COUNT_BITS = 22;

    // A clear transaction sweeps the whole pair memory; a pixel or clear
    // leaves no result behind, so idle waits cover a full sweep.
    localparam int SWEEP_CYCLES  = MAX_LABELS * MAX_LABELS;
    localparam int SETTLE_CYCLES = SWEEP_CYCLES + 32;
    localparam int END_CYCLES    = 64;
    localparam int CYCLE_LIMIT   = 1_500_000;

    // Fourth action code: accepted, ignored, no result.
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

    localparam logic [EDGE_W-1:0] COUNT_SAT = {EDGE_W{1'b1}};

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [ACTION_W-1:0]    action;
    logic [LABEL_W-1:0]     label;
    logic [LABEL_W-1:0]     row_label;
    logic [LABEL_W-1:0]     col_label;
    logic                   out_valid;
    logic                   out_stall;
    logic [EDGE_W-1:0]      edge_count;

    label_adjacency_counter_top #(
        .MAX_LABELS (MAX_LABELS),
        .MAX_WIDTH  (MAX_WIDTH),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .label      (label),
        .row_label  (row_label),
        .col_label  (col_label),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .edge_count (edge_count)
    );

    // ------------------------------------------------------------------------
    // Bench-side copy of the block state
    // ------------------------------------------------------------------------
    logic [EDGE_W-1:0]  adj_counts [MAX_LABELS][MAX_LABELS]; // [lo-1][hi-1] used
    logic [LABEL_W-1:0] row_above  [MAX_WIDTH];
    logic [LABEL_W-1:0] left_lab;
    int                 col_pos;
    bit                 on_first_row;
    int                 cfg_width;
    int                 cfg_regions;

    // Counts still owed by the block, oldest first
    logic [EDGE_W-1:0]  pending_counts [$];

    int error_count;
    int cycle_count;

    // Idling controls shared by the sender, the sink and the tests
    bit send_idle_on;
    bit recv_idle_on;
    int sink_hold_cycles;

    function automatic bit label_valid(input logic [LABEL_W-1:0] lab);
        return int'(lab) >= 1 && int'(lab) <= cfg_regions && int'(lab) <= MAX_LABELS;
    endfunction

    // One crack edge between two labels; equal or invalid labels don't count.
    function automatic void tally_crack(input logic [LABEL_W-1:0] a,
                                        input logic [LABEL_W-1:0] b);
        int lo;
        int hi;
        if (!label_valid(a) || !label_valid(b) || a == b)
            return;
        lo = (a < b) ? int'(a) : int'(b);
        hi = (a < b) ? int'(b) : int'(a);
        if (adj_counts[lo-1][hi-1] != COUNT_SAT)
            adj_counts[lo-1][hi-1] = adj_counts[lo-1][hi-1] + 1'b1;
    endfunction

    function automatic int row_length();
        if (cfg_width == 0)
            return 1;
        if (cfg_width > MAX_WIDTH)
            return MAX_WIDTH;
        return cfg_width;
    endfunction

    // Clear: counters, column and left label; line buffer is hidden by first row.
    function automatic void start_frame_counts();
        for (int i = 0; i < MAX_LABELS; i++)
            for (int j = 0; j < MAX_LABELS; j++)
                adj_counts[i][j] = '0;
        left_lab     = '0;
        col_pos      = 0;
        on_first_row = 1'b1;
    endfunction

    function automatic void reset_counts();
        cfg_width   = int'(IMAGE_WIDTH_RESET);
        cfg_regions = int'(REGION_COUNT_RESET);
        for (int i = 0; i < MAX_WIDTH; i++)
            row_above[i] = '0;
        start_frame_counts();
    endfunction

    function automatic void apply_pixel(input logic [LABEL_W-1:0] lab);
        int pos;
        pos = col_pos;
        if (pos >= MAX_WIDTH)
            pos = MAX_WIDTH - 1;
        if (pos > 0)
            tally_crack(left_lab, lab);
        if (!on_first_row)
            tally_crack(row_above[pos], lab);
        row_above[pos] = lab;
        left_lab = lab;
        pos++;
        // a width change mid-row ends the row once the column reaches it
        if (pos >= row_length())
        begin
            pos = 0;
            on_first_row = 1'b0;
        end
        col_pos = pos;
    endfunction

    function automatic logic [EDGE_W-1:0] pair_count(input logic [LABEL_W-1:0] a,
                                                     input logic [LABEL_W-1:0] b);
        int lo;
        int hi;
        if (!label_valid(a) || !label_valid(b))
            return '0;
        if (a == b)
            return EDGE_W'(1);
        lo = (a < b) ? int'(a) : int'(b);
        hi = (a < b) ? int'(b) : int'(a);
        return adj_counts[lo-1][hi-1];
    endfunction

    // Called once per accepted input transaction.
    function automatic void apply_transaction(input logic [ACTION_W-1:0] act,
                                              input logic [LABEL_W-1:0] lab,
                                              input logic [LABEL_W-1:0] rl,
                                              input logic [LABEL_W-1:0] cl);
        case (act)
            ACT_CLEAR: start_frame_counts();
            ACT_PIXEL: apply_pixel(lab);
            ACT_READ:  pending_counts.push_back(pair_count(rl, cl));
            default:   ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result sink: per-result random stall, plus a long hold-off that a test
    // can request through sink_hold_cycles (counted down here).
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
                stall_left = recv_idle_on ? $urandom_range(0, 15) : 0;
            if (sink_hold_cycles > 0)
            begin
                sink_hold_cycles--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------------
    initial
    begin : result_check
        logic [EDGE_W-1:0] want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_counts.size() == 0)
                begin
                    $error("edge_count: unexpected result, actual %0d", edge_count);
                    error_count++;
                end
                else
                begin
                    want = pending_counts.pop_front();
                    if (edge_count !== want)
                    begin
                        $error("edge_count mismatch: expected %0d, actual %0d",
                               want, edge_count);
                        error_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender. in_valid stays high after acceptance so a back-to-back
    // transaction can follow in the same step; anything that spends time
    // without sending lowers it first (see drain_results).
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [ACTION_W-1:0] act,
                             input logic [LABEL_W-1:0]  lab,
                             input logic [LABEL_W-1:0]  rl,
                             input logic [LABEL_W-1:0]  cl);
        int gap;
        gap = send_idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        label     <= lab;
        row_label <= rl;
        col_label <= cl;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        apply_transaction(act, lab, rl, cl);
    endtask

    task automatic send_pixel(input logic [LABEL_W-1:0] lab);
        send_item(ACT_PIXEL, lab, LABEL_W'($urandom_range(0, 127)),
                  LABEL_W'($urandom_range(0, 127)));
    endtask

    task automatic send_read(input logic [LABEL_W-1:0] rl, input logic [LABEL_W-1:0] cl);
        send_item(ACT_READ, LABEL_W'($urandom_range(0, 127)), rl, cl);
    endtask

    task automatic send_clear();
        send_item(ACT_CLEAR, LABEL_W'($urandom_range(0, 127)),
                  LABEL_W'($urandom_range(0, 127)), LABEL_W'($urandom_range(0, 127)));
    endtask

    // Sender pause: nothing offered until every owed result has come.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_counts.size() != 0);
    endtask

    // Idle the block fully (a clear may still be sweeping) and load both registers.
    task automatic configure(input int width, input int regions);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= CFG_DATA_W'(width);
        @(posedge clk);
        cfg_index <= CFG_REGION_COUNT;
        cfg_data  <= CFG_DATA_W'(regions & 'h7F);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_width   = width & 'h7FF;
        cfg_regions = regions & 'h7F;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values: diagonal, top label, label zero and out-of-range labels.
    task automatic test_reset_defaults();
        send_read(7'd1, 7'd1);
        send_read(7'd64, 7'd64);
        send_read(7'd0, 7'd0);
        send_read(7'd65, 7'd127);
    endtask

    // 3x3 frame with a zero label, an over-range label, equal neighbors,
    // the spare action and symmetric reads.
    task automatic test_small_frame();
        configure(3, 5);
        send_clear();
        send_pixel(7'd1); send_pixel(7'd2); send_pixel(7'd2);
        send_pixel(7'd3); send_pixel(7'd0); send_pixel(7'd2);
        send_pixel(7'd5); send_pixel(7'd6); send_pixel(7'd1);
        send_item(ACT_SPARE, 7'd127, 7'd127, 7'd127);
        send_read(7'd1, 7'd2);
        send_read(7'd2, 7'd1);
        send_read(7'd2, 7'd3);
        send_read(7'd1, 7'd5);
        send_read(7'd5, 7'd5);
    endtask

    // Width 0 behaves as one pixel per row; region count above the label
    // limit is capped.
    task automatic test_width_zero();
        configure(0, 127);
        send_clear();
        send_pixel(7'd64);
        send_pixel(7'd1);
        send_pixel(7'd64);
        send_read(7'd1, 7'd64);
        send_read(7'd64, 7'd127);
    endtask

    // Widest register value acts as the line-buffer size: rows wrap at 1024.
    task automatic test_wide_rows();
        configure(2047, 4);
        send_clear();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b1;
        for (int i = 0; i < MAX_WIDTH + 6; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_pixel(LABEL_W'($urandom_range(0, 1) * 5));
            else
                send_pixel(LABEL_W'($urandom_range(1, 4)));
            if (i == MAX_WIDTH / 2)
                send_idle_on = 1'b1;
        end
        for (int r = 1; r <= 4; r++)
            for (int c = 1; c <= 4; c++)
                send_read(LABEL_W'(r), LABEL_W'(c));
        send_read(7'd5, 7'd5);
    endtask

    // Sink holds off long enough for the output register to fill and the
    // input to stall; the sender keeps offering reads, then pauses.
    task automatic test_backpressure();
        send_idle_on = 1'b0;
        sink_hold_cycles = 300;
        for (int i = 0; i < 30; i++)
            send_read(LABEL_W'($urandom_range(1, 4)), LABEL_W'($urandom_range(1, 4)));
        drain_results();
        for (int i = 0; i < 10; i++)
            send_read(LABEL_W'($urandom_range(0, 5)), LABEL_W'($urandom_range(0, 5)));
        send_idle_on = 1'b1;
    endtask

    // Phases of mostly well-formed frames over a small label palette, with
    // noise labels, random reads, the spare action and the odd clear.
    // Some phases keep the frame running, so the width changes mid-row.
    task automatic test_random_phases(input int phases, input int items_per_phase);
        int width;
        int regions;
        int hi_lab;
        int sel;
        logic [LABEL_W-1:0] palette [4];
        for (int p = 0; p < phases; p++)
        begin
            case (p)
                0:
                begin
                    width   = 1;
                    regions = 1;
                end
                1:
                begin
                    width   = 2;
                    regions = 0;
                end
                2:
                begin
                    width   = 1024;
                    regions = 64;
                end
                default:
                begin
                    case ($urandom_range(0, 9))
                        0:       width = 0;
                        1:       width = 1;
                        2:       width = 2;
                        default: width = $urandom_range(2, 12);
                    endcase
                    case ($urandom_range(0, 7))
                        0:       regions = 1;
                        1:       regions = 64;
                        2:       regions = $urandom_range(65, 127);
                        default: regions = $urandom_range(2, 8);
                    endcase
                end
            endcase
            configure(width, regions);
            hi_lab = (regions < 1) ? 8 : ((regions > MAX_LABELS) ? MAX_LABELS : regions);
            for (int k = 0; k < 4; k++)
                palette[k] = LABEL_W'($urandom_range(1, hi_lab));
            if ($urandom_range(0, 3) != 0)
                send_clear();
            for (int i = 0; i < items_per_phase; i++)
            begin
                if (i % 40 == 0)
                begin
                    send_idle_on = $urandom_range(0, 2) != 0;
                    recv_idle_on = $urandom_range(0, 2) != 0;
                end
                sel = $urandom_range(0, 99);
                if (sel < 1)
                    send_clear();
                else if (sel < 3)
                    send_item(ACT_SPARE, LABEL_W'($urandom_range(0, 127)),
                              LABEL_W'($urandom_range(0, 127)),
                              LABEL_W'($urandom_range(0, 127)));
                else if (sel < 20)
                begin
                    case ($urandom_range(0, 9))
                        7:       send_read(palette[i % 4], palette[i % 4]);
                        8, 9:    send_read(LABEL_W'($urandom_range(0, 127)),
                                           LABEL_W'($urandom_range(0, 127)));
                        default: send_read(palette[$urandom_range(0, 3)],
                                           palette[$urandom_range(0, 3)]);
                    endcase
                end
                else if ($urandom_range(0, 9) < 8)
                    send_pixel(palette[$urandom_range(0, 3)]);
                else
                    send_pixel(LABEL_W'($urandom_range(0, 127)));
            end
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        error_count      = 0;
        send_idle_on     = 1'b1;
        recv_idle_on     = 1'b1;
        sink_hold_cycles = 0;
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        action    <= ACT_CLEAR;
        label     <= '0;
        row_label <= '0;
        col_label <= '0;
        reset_counts();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // The reset sweep holds in_stall high; the sender simply waits it out.
        test_reset_defaults();
        test_small_frame();
        test_width_zero();
        test_wide_rows();
        test_backpressure();
        test_random_phases(10, 100);

        drain_results();
        repeat (END_CYCLES) @(posedge clk);
        if (pending_counts.size() != 0)
        begin
            $error("edge_count: %0d results never arrived", pending_counts.size());
            error_count++;
        end
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
